// File: src/sesf_pkg.sv
// Shared types and constants for the stack engine with search filter.
// Used by the controller, the datapath, the top level and the checker.
package sesf_pkg;

    localparam int SESF_STACK_DEPTH = 64;
    localparam int SESF_DATA_W      = 32;
    localparam int SESF_COUNT_W     = 7;

    typedef enum logic [2:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_PEEK   = 3'd2,
        ACT_SEARCH = 3'd3,
        ACT_REMOVE = 3'd4,
        ACT_EVEN   = 3'd5,
        ACT_DEDUP  = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_USE,
        S_SRCH_CMP,
        S_RM_CMP,
        S_RM_SHIFT,
        S_EVEN_CMP,
        S_DD_X,
        S_DD_CMP,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {RA_I, RA_INEXT, RA_IPREV, RA_I2, RA_JNEXT, RA_TOP} rsel_t;
    typedef enum logic [1:0] {WA_FILL, WA_W, WA_I} wsel_t;
    typedef enum logic [1:0] {WD_OPER, WD_RDATA, WD_X} dsel_t;
    typedef enum logic [2:0] {I_HOLD, I_CLR, I_TOP, I_INC, I_DEC} iop_t;
    typedef enum logic [1:0] {J_HOLD, J_INIT, J_INC} jop_t;
    typedef enum logic [1:0] {W_HOLD, W_CLR, W_INC} wop_t;
    typedef enum logic [1:0] {F_HOLD, F_INC, F_DEC, F_W} fop_t;

    typedef struct packed {
        logic    load;
        rsel_t   rd_sel;
        logic    wr_en;
        wsel_t   wa_sel;
        dsel_t   wd_sel;
        iop_t    i_op;
        jop_t    j_op;
        wop_t    w_op;
        fop_t    f_op;
        logic    x_load;
        logic    status_we;
        status_t status_val;
        logic    data_load;
        logic    hit_set;
    } cmd_t;

    typedef struct packed {
        action_t op;
        logic    fill_zero;
        logic    full;
        logic    i_last;
        logic    i_next_last;
        logic    i_zero;
        logic    j_last;
        logic    rd_eq_oper;
        logic    rd_eq_x;
        logic    rd_odd;
    } stat_t;

endpackage

// File: src/sesf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sesf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/sesf_datapath.sv
// Datapath of the stack engine: entry store, fill level, walk indexes and result registers.
// Depends on sesf_pkg and sesf_ram; driven by commands from sesf_ctrl.
module sesf_datapath #(
    parameter int STACK_DEPTH = sesf_pkg::SESF_STACK_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sesf_pkg::cmd_t                       cmd,
    output sesf_pkg::stat_t                      stat,
    input  logic [2:0]                           action,
    input  logic signed [sesf_pkg::SESF_DATA_W-1:0] operand_value,
    output logic [1:0]                           status,
    output logic signed [sesf_pkg::SESF_DATA_W-1:0] data_out,
    output logic                                 hit,
    output logic [sesf_pkg::SESF_COUNT_W-1:0]    entry_count,
    output logic                                 is_empty
);
    import sesf_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int FW = $clog2(STACK_DEPTH + 1);

    action_t              op_reg;
    logic [SESF_DATA_W-1:0] oper_reg;
    logic [SESF_DATA_W-1:0] x_reg;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [AW-1:0]        i_reg, i_next;
    logic [AW-1:0]        j_reg, j_next;
    logic [FW-1:0]        w_reg, w_next;
    status_t              status_reg;
    logic [SESF_DATA_W-1:0] data_reg;
    logic                 hit_reg;

    logic [AW-1:0]        raddr, waddr;
    logic [SESF_DATA_W-1:0] wdata, rdata;
    logic [FW-1:0]        i_ext, j_ext;

    sesf_ram #(
        .WIDTH (SESF_DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign i_ext = FW'(i_reg);
    assign j_ext = FW'(j_reg);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RA_I:     raddr = i_reg;
            RA_INEXT: raddr = i_reg + AW'(1);
            RA_IPREV: raddr = i_reg - AW'(1);
            RA_I2:    raddr = AW'(i_ext + FW'(2));
            RA_JNEXT: raddr = j_reg + AW'(1);
            RA_TOP:   raddr = AW'(fill_reg - FW'(1));
            default:  raddr = i_reg;
        endcase
        unique case (cmd.wa_sel)
            WA_FILL: waddr = AW'(fill_reg);
            WA_W:    waddr = AW'(w_reg);
            WA_I:    waddr = i_reg;
            default: waddr = i_reg;
        endcase
        unique case (cmd.wd_sel)
            WD_OPER:  wdata = oper_reg;
            WD_RDATA: wdata = rdata;
            WD_X:     wdata = x_reg;
            default:  wdata = rdata;
        endcase
    end

    always_comb
    begin
        unique case (cmd.i_op)
            I_CLR:   i_next = '0;
            I_TOP:   i_next = AW'(fill_reg - FW'(1));
            I_INC:   i_next = i_reg + AW'(1);
            I_DEC:   i_next = i_reg - AW'(1);
            default: i_next = i_reg;
        endcase
        unique case (cmd.j_op)
            J_INIT:  j_next = i_reg + AW'(1);
            J_INC:   j_next = j_reg + AW'(1);
            default: j_next = j_reg;
        endcase
        unique case (cmd.w_op)
            W_CLR:   w_next = '0;
            W_INC:   w_next = w_reg + FW'(1);
            default: w_next = w_reg;
        endcase
        // The filters rewrite the fill level with the write pointer, including
        // the entry kept in the same cycle.
        unique case (cmd.f_op)
            F_INC:   fill_next = fill_reg + FW'(1);
            F_DEC:   fill_next = fill_reg - FW'(1);
            F_W:     fill_next = w_next;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            w_reg      <= '0;
            op_reg     <= ACT_PUSH;
            status_reg <= ST_OK;
            hit_reg    <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            w_reg    <= w_next;
            if (cmd.load)
            begin
                op_reg     <= action_t'(action);
                status_reg <= ST_OK;
                hit_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.status_we)
                begin
                    status_reg <= cmd.status_val;
                end
                if (cmd.hit_set)
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            oper_reg <= operand_value;
            data_reg <= '0;
        end
        else if (cmd.data_load)
        begin
            data_reg <= rdata;
        end
        if (cmd.x_load)
        begin
            x_reg <= rdata;
        end
    end

    always_comb
    begin
        stat.op          = op_reg;
        stat.fill_zero   = (fill_reg == '0);
        stat.full        = (fill_reg == FW'(STACK_DEPTH));
        stat.i_last      = (i_ext + FW'(1) == fill_reg);
        stat.i_next_last = (i_ext + FW'(2) == fill_reg);
        stat.i_zero      = (i_reg == '0);
        stat.j_last      = (j_ext + FW'(1) == fill_reg);
        stat.rd_eq_oper  = (rdata == oper_reg);
        stat.rd_eq_x     = (rdata == x_reg);
        stat.rd_odd      = rdata[0];
    end

    assign status      = status_reg;
    assign data_out    = data_reg;
    assign hit         = hit_reg;
    assign entry_count = SESF_COUNT_W'(fill_reg);
    assign is_empty    = (fill_reg == '0);

endmodule

// File: src/sesf_ctrl.sv
// Controller of the stack engine: sequences each command over the datapath.
// Depends on sesf_pkg; talks to sesf_datapath through cmd_t and stat_t.
module sesf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            done,
    input  sesf_pkg::stat_t stat,
    output sesf_pkg::cmd_t  cmd
);
    import sesf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy       = (state_reg != S_IDLE);
        done       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cmd.i_op   = I_CLR;
                    cmd.w_op   = W_CLR;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                state_next = S_DONE;
                unique case (stat.op)
                    ACT_PUSH:
                    begin
                        if (stat.full)
                        begin
                            cmd.status_we  = 1'b1;
                            cmd.status_val = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = WA_FILL;
                            cmd.wd_sel = WD_OPER;
                            cmd.f_op   = F_INC;
                        end
                    end
                    ACT_POP, ACT_PEEK:
                    begin
                        if (stat.fill_zero)
                        begin
                            cmd.status_we  = 1'b1;
                            cmd.status_val = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_sel = RA_TOP;
                            state_next = S_POP_USE;
                        end
                    end
                    ACT_SEARCH:
                    begin
                        if (!stat.fill_zero)
                        begin
                            cmd.rd_sel = RA_I;
                            state_next = S_SRCH_CMP;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (!stat.fill_zero)
                        begin
                            cmd.rd_sel = RA_TOP;
                            cmd.i_op   = I_TOP;
                            state_next = S_RM_CMP;
                        end
                    end
                    ACT_EVEN:
                    begin
                        if (!stat.fill_zero)
                        begin
                            cmd.rd_sel = RA_I;
                            state_next = S_EVEN_CMP;
                        end
                    end
                    ACT_DEDUP:
                    begin
                        if (!stat.fill_zero)
                        begin
                            cmd.rd_sel = RA_I;
                            state_next = S_DD_X;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_POP_USE:
            begin
                cmd.data_load = 1'b1;
                if (stat.op == ACT_POP)
                begin
                    cmd.f_op = F_DEC;
                end
                state_next = S_DONE;
            end

            S_SRCH_CMP:
            begin
                if (stat.rd_eq_oper)
                begin
                    cmd.hit_set = 1'b1;
                    state_next  = S_DONE;
                end
                else if (stat.i_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.i_op   = I_INC;
                    cmd.rd_sel = RA_INEXT;
                end
            end

            // Walks down from the top; the first match is closed up by shifting
            // the entries above it down one place.
            S_RM_CMP:
            begin
                if (stat.rd_eq_oper)
                begin
                    cmd.hit_set = 1'b1;
                    if (stat.i_last)
                    begin
                        cmd.f_op   = F_DEC;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.rd_sel = RA_INEXT;
                        state_next = S_RM_SHIFT;
                    end
                end
                else if (stat.i_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.i_op   = I_DEC;
                    cmd.rd_sel = RA_IPREV;
                end
            end

            S_RM_SHIFT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_I;
                cmd.wd_sel = WD_RDATA;
                if (stat.i_next_last)
                begin
                    cmd.f_op   = F_DEC;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.i_op   = I_INC;
                    cmd.rd_sel = RA_I2;
                end
            end

            S_EVEN_CMP:
            begin
                if (stat.rd_odd)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = WA_W;
                    cmd.wd_sel = WD_RDATA;
                    cmd.w_op   = W_INC;
                end
                else
                begin
                    cmd.hit_set = 1'b1;
                end
                if (stat.i_last)
                begin
                    cmd.f_op   = F_W;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.i_op   = I_INC;
                    cmd.rd_sel = RA_INEXT;
                end
            end

            // Candidate entry i is captured; the topmost entry is always kept.
            S_DD_X:
            begin
                cmd.x_load = 1'b1;
                if (stat.i_last)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = WA_W;
                    cmd.wd_sel = WD_RDATA;
                    cmd.w_op   = W_INC;
                    cmd.f_op   = F_W;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.j_op   = J_INIT;
                    cmd.rd_sel = RA_INEXT;
                    state_next = S_DD_CMP;
                end
            end

            S_DD_CMP:
            begin
                if (stat.rd_eq_x)
                begin
                    cmd.hit_set = 1'b1;
                    cmd.i_op    = I_INC;
                    cmd.rd_sel  = RA_INEXT;
                    state_next  = S_DD_X;
                end
                else if (stat.j_last)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = WA_W;
                    cmd.wd_sel = WD_X;
                    cmd.w_op   = W_INC;
                    cmd.i_op   = I_INC;
                    cmd.rd_sel = RA_INEXT;
                    state_next = S_DD_X;
                end
                else
                begin
                    cmd.j_op   = J_INC;
                    cmd.rd_sel = RA_JNEXT;
                end
            end

            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/stack_engine_with_search_filter.sv
// Bounded LIFO stack engine with search, remove and filter commands.
// Depends on sesf_pkg, sesf_ctrl, sesf_datapath and sesf_ram.
//
// A command is taken when start is high while busy is low; busy then stays high
// until its single result has been shown. The result is on the output ports for
// exactly one cycle, marked by done, and must be captured then, since the
// receiver cannot stall the block. Search and remove-even walk up through the
// entries, remove-first-match walks down and then closes the gap, and
// remove-duplicates compares every entry against those above it. The one read
// port of the entry RAM, one entry per cycle, paces these walks. The entry
// RAM needs no clearing after reset; only entries below the fill level are
// ever read.
module stack_engine_with_search_filter #(
    parameter int STACK_DEPTH = sesf_pkg::SESF_STACK_DEPTH
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [2:0]                              action,
    input  logic signed [sesf_pkg::SESF_DATA_W-1:0] operand_value,
    output logic                                    done,
    output logic [1:0]                              status,
    output logic signed [sesf_pkg::SESF_DATA_W-1:0] data_out,
    output logic                                    hit,
    output logic [sesf_pkg::SESF_COUNT_W-1:0]       entry_count,
    output logic                                    is_empty
);
    import sesf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sesf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    sesf_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (action),
        .operand_value (operand_value),
        .status        (status),
        .data_out      (data_out),
        .hit           (hit),
        .entry_count   (entry_count),
        .is_empty      (is_empty)
    );

endmodule

// File: src/sesf_checker.sv
// Port-level checker for the stack engine, bound to the top level.
// Depends on sesf_pkg and stack_engine_with_search_filter.
module sesf_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    start,
    input logic                                    busy,
    input logic                                    done,
    input logic [1:0]                              status,
    input logic signed [sesf_pkg::SESF_DATA_W-1:0] data_out,
    input logic                                    hit,
    input logic [sesf_pkg::SESF_COUNT_W-1:0]       entry_count,
    input logic                                    is_empty
);
    import sesf_pkg::*;

    // An accepted transaction keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a transaction");

    // Each transaction yields one result strobe, never two in a row.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // An empty pop or peek returns zero data and reports an empty stack.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_EMPTY) |-> (data_out == '0 && is_empty && entry_count == '0))
        else $error("empty status with data or non-empty stack");

    // A failed command never reports a hit.
    a_no_hit_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> !hit)
        else $error("hit reported together with an error status");

    // A full push leaves the stack non-empty.
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> !is_empty)
        else $error("full status reported on an empty stack");

endmodule

bind stack_engine_with_search_filter sesf_checker u_sesf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .data_out      (data_out),
    .hit           (hit),
    .entry_count   (entry_count),
    .is_empty      (is_empty)
);

// File: test/testbench.sv
// Self-checking testbench for the bounded LIFO stack engine with search and filters.
// Depends on sesf_pkg and stack_engine_with_search_filter; it keeps its own mirror of
// the stack and checks every result strobe against the mirror's prediction.
`timescale 1ns / 1ps

module testbench;
    import sesf_pkg::*;

    localparam int          DEPTH       = SESF_STACK_DEPTH;
    localparam logic [2:0]  ACT_NOP     = 3'd7;
    localparam int          CYCLE_LIMIT = 8_000_000;
    localparam int          PRINT_LIMIT = 40;

    typedef struct packed {
        status_t            st;
        logic signed [31:0] data;
        logic               hit;
        logic [6:0]         count;
        logic               empty;
    } stack_result_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               start         = 1'b0;
    logic [2:0]         action        = 3'd0;
    logic signed [31:0] operand_value = 32'sd0;
    logic               busy;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] data_out;
    logic               hit;
    logic [6:0]         entry_count;
    logic               is_empty;

    // Mirror of the stack contents; entry 0 is the bottom.
    logic [31:0]        mirror_entries [DEPTH];
    int                 mirror_fill    = 0;
    stack_result_t      pending_results [$];

    int                 error_count     = 0;
    int                 commands_sent   = 0;
    int                 results_checked = 0;
    int                 full_refusals   = 0;
    int                 empty_reads     = 0;
    int                 hit_count       = 0;
    int                 peak_fill       = 0;
    int                 cycle_count     = 0;

    stack_engine_with_search_filter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .operand_value (operand_value),
        .done          (done),
        .status        (status),
        .data_out      (data_out),
        .hit           (hit),
        .entry_count   (entry_count),
        .is_empty      (is_empty)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Applies one command to the mirror and returns the result it must produce.
    function automatic stack_result_t apply_stack_command(input logic [2:0] act,
                                                          input logic [31:0] val);
        stack_result_t r;
        int            w;
        bit            dup;
        r.st    = ST_OK;
        r.data  = '0;
        r.hit   = 1'b0;
        case (act)
            ACT_PUSH:
            begin
                if (mirror_fill >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    mirror_entries[mirror_fill] = val;
                    mirror_fill++;
                end
            end
            ACT_POP, ACT_PEEK:
            begin
                if (mirror_fill == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    r.data = mirror_entries[mirror_fill - 1];
                    if (act == ACT_POP)
                        mirror_fill--;
                end
            end
            ACT_SEARCH:
            begin
                for (int i = 0; i < mirror_fill; i++)
                    if (mirror_entries[i] == val)
                        r.hit = 1'b1;
            end
            ACT_REMOVE:
            begin
                // Only the topmost match goes; the entries above it slide down.
                for (int i = mirror_fill - 1; i >= 0 && !r.hit; i--)
                begin
                    if (mirror_entries[i] == val)
                    begin
                        for (int k = i; k + 1 < mirror_fill; k++)
                            mirror_entries[k] = mirror_entries[k + 1];
                        mirror_fill--;
                        r.hit = 1'b1;
                    end
                end
            end
            ACT_EVEN:
            begin
                w = 0;
                for (int i = 0; i < mirror_fill; i++)
                begin
                    if (mirror_entries[i][0])
                    begin
                        mirror_entries[w] = mirror_entries[i];
                        w++;
                    end
                    else
                        r.hit = 1'b1;
                end
                mirror_fill = w;
            end
            ACT_DEDUP:
            begin
                // An entry survives only when no equal value sits above it.
                w = 0;
                for (int i = 0; i < mirror_fill; i++)
                begin
                    dup = 1'b0;
                    for (int j = i + 1; j < mirror_fill; j++)
                        if (mirror_entries[j] == mirror_entries[i])
                            dup = 1'b1;
                    if (dup)
                        r.hit = 1'b1;
                    else
                    begin
                        mirror_entries[w] = mirror_entries[i];
                        w++;
                    end
                end
                mirror_fill = w;
            end
            default:
            begin
            end
        endcase
        r.count = mirror_fill[6:0];
        r.empty = (mirror_fill == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("Mismatch on %s of result %0d: got %h, expected %h",
                     field, results_checked, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected strobe", 32'd0, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
                if (data_out !== want.data)
                    report_mismatch("data_out", data_out, want.data);
                if (hit !== want.hit)
                    report_mismatch("hit", hit, want.hit);
                if (entry_count !== want.count)
                    report_mismatch("entry_count", entry_count, want.count);
                if (is_empty !== want.empty)
                    report_mismatch("is_empty", is_empty, want.empty);
            end
            results_checked++;
        end
    end

    // Presents one command and returns at the edge where the transaction is taken.
    task automatic send_command(input logic [2:0] act, input logic [31:0] val);
        stack_result_t want;
        start         <= 1'b1;
        action        <= act;
        operand_value <= val;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        want = apply_stack_command(act, val);
        pending_results.push_back(want);
        commands_sent++;
        if (want.st == ST_FULL)
            full_refusals++;
        if (want.st == ST_EMPTY)
            empty_reads++;
        if (want.hit)
            hit_count++;
        if (mirror_fill > peak_fill)
            peak_fill = mirror_fill;
    endtask

    task automatic idle_gap(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Values come mostly from a small pool so that searches and filters find matches.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $urandom_range(0, 7);
            6:                return -$urandom_range(1, 4);
            7:                return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default:          return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_target();
        if (mirror_fill != 0 && $urandom_range(0, 9) < 7)
            return mirror_entries[$urandom_range(0, mirror_fill - 1)];
        return pick_value();
    endfunction

    task automatic test_empty_stack();
        send_command(ACT_POP, 32'h1234_5678);
        send_command(ACT_PEEK, 32'hFFFF_FFFF);
        send_command(ACT_SEARCH, 32'h0);
        send_command(ACT_REMOVE, 32'h0);
        send_command(ACT_EVEN, 32'h0);
        send_command(ACT_DEDUP, 32'h0);
        send_command(ACT_NOP, 32'hA5A5_A5A5);
    endtask

    task automatic test_field_extremes();
        send_command(ACT_PUSH, 32'h8000_0000);
        send_command(ACT_PUSH, 32'h7FFF_FFFF);
        send_command(ACT_PUSH, 32'h0000_0000);
        send_command(ACT_PUSH, 32'hFFFF_FFFF);
        send_command(ACT_PEEK, 32'h0);
        send_command(ACT_SEARCH, 32'h8000_0000);
        send_command(ACT_SEARCH, 32'h0001_2345);
        send_command(ACT_REMOVE, 32'h0000_0000);
        send_command(ACT_REMOVE, 32'h0000_0000);
        send_command(ACT_PUSH, 32'h7FFF_FFFF);
        send_command(ACT_DEDUP, 32'h0);
        send_command(ACT_EVEN, 32'h0);
        send_command(ACT_EVEN, 32'h0);
        send_command(ACT_DEDUP, 32'h0);
        repeat (4) send_command(ACT_POP, 32'h0);
    endtask

    // Fills the stack to capacity, refuses pushes, runs remove-duplicates on a full
    // stack, then remove-even on what is left, and then pops it empty.
    task automatic test_capacity();
        while (mirror_fill < DEPTH)
            send_command(ACT_PUSH, pick_value());
        send_command(ACT_PUSH, $urandom());
        send_command(ACT_PUSH, pick_value());
        send_command(ACT_PEEK, 32'h0);
        send_command(ACT_SEARCH, pick_target());
        send_command(ACT_REMOVE, mirror_entries[DEPTH / 2]);
        while (mirror_fill < DEPTH)
            send_command(ACT_PUSH, pick_value());
        send_command(ACT_DEDUP, 32'h0);
        send_command(ACT_EVEN, 32'h0);
        while (mirror_fill > 0)
            send_command(ACT_POP, pick_value());
        send_command(ACT_POP, 32'h0);
    endtask

    task automatic test_random_mix(input int count, input bit with_idle);
        int         push_weight;
        int         roll;
        logic [2:0] act;
        repeat (count)
        begin
            if (with_idle && $urandom_range(0, 4) == 0)
                idle_gap($urandom_range(1, 16));
            // Keep the stack shallow most of the time so that the filters stay quick.
            push_weight = (mirror_fill < 4) ? 55 : (mirror_fill > 20) ? 10 : 30;
            if ($urandom_range(0, 99) < push_weight)
                act = ACT_PUSH;
            else
            begin
                roll = $urandom_range(0, 69);
                if (roll < 20)
                    act = ACT_POP;
                else if (roll < 30)
                    act = ACT_PEEK;
                else if (roll < 42)
                    act = ACT_SEARCH;
                else if (roll < 54)
                    act = ACT_REMOVE;
                else if (roll < 60)
                    act = ACT_EVEN;
                else if (roll < 68)
                    act = ACT_DEDUP;
                else
                    act = ACT_NOP;
            end
            if (act == ACT_SEARCH || act == ACT_REMOVE)
                send_command(act, pick_target());
            else
                send_command(act, pick_value());
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_stack();
        test_field_extremes();
        wait_for_results();
        test_capacity();
        test_random_mix(520, 1'b1);
        wait_for_results();
        test_random_mix(150, 1'b0);

        wait_for_results();
        repeat (40) @(posedge clk);

        $display("Ran %0d commands, %0d results checked, %0d with a hit; peak fill %0d of %0d.",
                 commands_sent, results_checked, hit_count, peak_fill, DEPTH);
        $display("Refused pushes on a full stack: %0d, reads of an empty stack: %0d.",
                 full_refusals, empty_reads);
        if (error_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
